// File: sv/spranim_pkg.sv
// shared constants for the sprite animation stepper
package spranim_pkg;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZOOM         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_FLAGS   = 3'd5;

	// mode flag bit positions
	localparam int FLAG_ANIM     = 0;
	localparam int FLAG_MULTI    = 1;
	localparam int FLAG_PLAY     = 2;
	localparam int FLAG_PINGPONG = 3;

	// field widths
	localparam int DIM_W   = 10;
	localparam int ZOOM_W  = 4;
	localparam int FRAME_W = 7;
	localparam int RATE_W  = 10;
	localparam int SRC_W   = 17;
	localparam int DST_W   = 14;

	// shared multiplier steps
	localparam logic [1:0] MUL_DST_W = 2'd0;
	localparam logic [1:0] MUL_DST_H = 2'd1;
	localparam logic [1:0] MUL_SRC_X = 2'd2;
	localparam logic [1:0] MUL_SRC_Y = 2'd3;

	// divider steps, one quotient bit each
	localparam int DIV_STEPS  = RATE_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

endpackage

// File: sv/sprite_animation_stepper_top.sv
// sprite animation stepper: rectangles per display tick and frame prescaler
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_stall  | pos_x, pos_y, row_select, display_rate
//  out     | out_valid/out_stall| src_x/y/w/h, dst_x/y/w/h, shown_frame
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data (ready always high)
//
// the result is registered after four passes through one shared 10x7
// multiplier and, when the prescaler reloads, ten steps of a restoring
// divider for display_rate / target_rate; the next tick is taken once
// the result has been written.
// in_stall stays high from accept until the result is written to the output
// register; a stalled result holds and blocks only the final write.
module sprite_animation_stepper_top (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [15:0]                     pos_x,
	input  logic signed [15:0]                     pos_y,
	input  logic [spranim_pkg::FRAME_W-1:0]        row_select,
	input  logic [spranim_pkg::RATE_W-1:0]         display_rate,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [spranim_pkg::SRC_W-1:0]          src_x,
	output logic [spranim_pkg::SRC_W-1:0]          src_y,
	output logic [spranim_pkg::DIM_W-1:0]          src_w,
	output logic [spranim_pkg::DIM_W-1:0]          src_h,
	output logic signed [16:0]                     dst_x,
	output logic signed [16:0]                     dst_y,
	output logic [spranim_pkg::DST_W-1:0]          dst_w,
	output logic [spranim_pkg::DST_W-1:0]          dst_h,
	output logic [spranim_pkg::FRAME_W-1:0]        shown_frame,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [spranim_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [spranim_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import spranim_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_DONE} state_t;

	state_t                state_q;
	logic [1:0]            mstep_q;
	logic [DIV_CNT_W-1:0]  dstep_q;

	// configuration registers
	logic [DIM_W-1:0]    fw_q, fh_q;
	logic [ZOOM_W-1:0]   zoom_q;
	logic [FRAME_W-1:0]  fcount_q, trate_q;
	logic [3:0]          mode_q;

	// frame state
	logic [FRAME_W-1:0]  cur_frame_q;
	logic                back_q;
	logic [RATE_W-1:0]   skip_q;

	// latched tick and partial results
	logic signed [15:0]  cx_q, cy_q;
	logic [FRAME_W-1:0]  row_q;
	logic [DST_W-1:0]    dw_q, dh_q;
	logic [SRC_W-1:0]    sx_q, sy_q;
	logic [FRAME_W-1:0]  rem_q;
	logic [RATE_W-1:0]   quo_q;
	logic                out_valid_q;

	logic                anim, play_step, reload;
	logic [DIM_W-1:0]    mul_a;
	logic [FRAME_W-1:0]  mul_b;
	logic [SRC_W-1:0]    mul_p;
	logic [FRAME_W-1:0]  divisor;
	logic [FRAME_W:0]    shifted;
	logic                fits;
	logic [FRAME_W-1:0]  fc_eff;
	logic signed [8:0]   n_step, n_next;
	logic                back_next;
	logic                out_free;
	logic signed [16:0]  dx_c, dy_c;

	assign anim      = mode_q[FLAG_ANIM];
	assign play_step = mode_q[FLAG_ANIM] & mode_q[FLAG_PLAY];
	assign reload    = play_step && (skip_q == '0);
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// shared multiplier operand select
	always_comb begin
		case (mstep_q)
			MUL_DST_W: begin
				mul_a = fw_q;
				mul_b = {{(FRAME_W-ZOOM_W){1'b0}}, zoom_q};
			end
			MUL_DST_H: begin
				mul_a = fh_q;
				mul_b = {{(FRAME_W-ZOOM_W){1'b0}}, zoom_q};
			end
			MUL_SRC_X: begin
				mul_a = fw_q;
				mul_b = row_q;
			end
			default: begin
				mul_a = fh_q;
				mul_b = cur_frame_q;
			end
		endcase
		mul_p = SRC_W'(mul_a) * SRC_W'(mul_b);
	end

	// divider trial subtract, zero target rate counts as one
	always_comb begin
		divisor = (trate_q == '0) ? FRAME_W'(1) : trate_q;
		shifted = {rem_q, quo_q[RATE_W-1]};
		fits    = (shifted >= {1'b0, divisor});
	end

	// next frame with wrap-around or ping-pong end rules
	always_comb begin
		fc_eff    = (fcount_q == '0) ? FRAME_W'(1) : fcount_q;
		n_step    = back_q ? ($signed({2'b00, cur_frame_q}) - 9'sd1)
		                   : ($signed({2'b00, cur_frame_q}) + 9'sd1);
		n_next    = n_step;
		back_next = back_q;
		if (n_step >= $signed({2'b00, fc_eff})) begin
			if (mode_q[FLAG_PINGPONG] && fc_eff >= FRAME_W'(2)) begin
				back_next = 1'b1;
				n_next    = $signed({2'b00, fc_eff}) - 9'sd2;
			end else begin
				if (mode_q[FLAG_PINGPONG])
					back_next = 1'b0;
				n_next = '0;
			end
		end else if (n_step < 9'sd0) begin
			if (mode_q[FLAG_PINGPONG]) begin
				back_next = 1'b0;
				n_next    = (fc_eff >= FRAME_W'(2)) ? 9'sd1 : 9'sd0;
			end else begin
				n_next = $signed({2'b00, fc_eff}) - 9'sd1;
			end
		end
	end

	// destination corner, center minus half the scaled size
	assign dx_c = $signed({cx_q[15], cx_q}) - $signed({4'b0000, dw_q[DST_W-1:1]});
	assign dy_c = $signed({cy_q[15], cy_q}) - $signed({4'b0000, dh_q[DST_W-1:1]});

	// sequencer, configuration, frame state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mstep_q     <= '0;
			dstep_q     <= '0;
			fw_q        <= '0;
			fh_q        <= '0;
			zoom_q      <= ZOOM_W'(1);
			fcount_q    <= FRAME_W'(1);
			trate_q     <= FRAME_W'(1);
			mode_q      <= '0;
			cur_frame_q <= '0;
			back_q      <= 1'b0;
			skip_q      <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			row_q       <= '0;
			dw_q        <= '0;
			dh_q        <= '0;
			sx_q        <= '0;
			sy_q        <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			out_valid_q <= 1'b0;
			src_x       <= '0;
			src_y       <= '0;
			src_w       <= '0;
			src_h       <= '0;
			dst_x       <= '0;
			dst_y       <= '0;
			dst_w       <= '0;
			dst_h       <= '0;
			shown_frame <= '0;
		end else begin
			// config beat
			if (cfg_valid) begin
				case (cfg_index)
					REG_FRAME_WIDTH:  fw_q     <= cfg_data;
					REG_FRAME_HEIGHT: fh_q     <= cfg_data;
					REG_ZOOM:         zoom_q   <= cfg_data[ZOOM_W-1:0];
					REG_FRAME_COUNT:  fcount_q <= cfg_data[FRAME_W-1:0];
					REG_TARGET_RATE:  trate_q  <= cfg_data[FRAME_W-1:0];
					REG_MODE_FLAGS:   mode_q   <= cfg_data[3:0];
					default: ;
				endcase
			end

			// result taken downstream
			if (out_valid_q && !out_stall && state_q != ST_DONE)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cx_q    <= pos_x;
						cy_q    <= pos_y;
						row_q   <= row_select;
						quo_q   <= display_rate;
						rem_q   <= '0;
						mstep_q <= MUL_DST_W;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					case (mstep_q)
						MUL_DST_W: dw_q <= mul_p[DST_W-1:0];
						MUL_DST_H: dh_q <= mul_p[DST_W-1:0];
						MUL_SRC_X: sx_q <= mul_p;
						default:   sy_q <= mul_p;
					endcase
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == MUL_SRC_Y) begin
						dstep_q <= '0;
						state_q <= reload ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					if (fits) begin
						rem_q <= FRAME_W'(shifted - {1'b0, divisor});
						quo_q <= {quo_q[RATE_W-2:0], 1'b1};
					end else begin
						rem_q <= shifted[FRAME_W-1:0];
						quo_q <= {quo_q[RATE_W-2:0], 1'b0};
					end
					dstep_q <= dstep_q + DIV_CNT_W'(1);
					if (dstep_q == DIV_CNT_W'(DIV_STEPS - 1))
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						src_x       <= (anim && mode_q[FLAG_MULTI]) ? sx_q : '0;
						src_y       <= anim ? sy_q : '0;
						src_w       <= fw_q;
						src_h       <= fh_q;
						dst_x       <= dx_c;
						dst_y       <= dy_c;
						dst_w       <= dw_q;
						dst_h       <= dh_q;
						shown_frame <= anim ? cur_frame_q : '0;
						out_valid_q <= 1'b1;
						// prescaler and frame step
						if (play_step) begin
							if (skip_q == '0) begin
								skip_q      <= quo_q;
								cur_frame_q <= n_next[FRAME_W-1:0];
								back_q      <= back_next;
							end else begin
								skip_q <= skip_q - RATE_W'(1);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	// no tick accepted while the sequencer is busy
	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input not stalled while busy");

	// divider never runs past its last step
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dstep_q <= DIV_CNT_W'(DIV_STEPS - 1)))
		else $error("divider step out of range");

	// frame state holds unless animated and playing
	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!play_step |=> ($stable(cur_frame_q) && $stable(back_q) && $stable(skip_q)))
		else $error("frame state moved while not playing");

	// a result is only written from the final state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid_q && state_q != ST_DONE) |=> !out_valid_q)
		else $error("result appeared outside the final state");

endmodule

// File: sim/tb_top.sv
// self-checking testbench for the sprite animation stepper
module tb_top;
	import spranim_pkg::*;

	// mode flag values
	localparam logic [3:0] M_ANIM  = 4'(1 << FLAG_ANIM);
	localparam logic [3:0] M_MULTI = 4'(1 << FLAG_MULTI);
	localparam logic [3:0] M_PLAY  = 4'(1 << FLAG_PLAY);
	localparam logic [3:0] M_PONG  = 4'(1 << FLAG_PINGPONG);

	// index with no register behind it, writes are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	localparam int HOLD_CYCLES = 200;

	typedef struct {
		logic signed [15:0]  cx;
		logic signed [15:0]  cy;
		logic [FRAME_W-1:0]  row;
		logic [RATE_W-1:0]   rate;
	} tick_t;

	typedef struct {
		logic [SRC_W-1:0]    sx;
		logic [SRC_W-1:0]    sy;
		logic [DIM_W-1:0]    sw;
		logic [DIM_W-1:0]    sh;
		logic signed [16:0]  dx;
		logic signed [16:0]  dy;
		logic [DST_W-1:0]    dw;
		logic [DST_W-1:0]    dh;
		logic [FRAME_W-1:0]  shown;
	} rect_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		tick_t                 t;
		bit                    typed;
		rect_t                 want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] pos_x = '0;
	logic signed [15:0] pos_y = '0;
	logic [FRAME_W-1:0] row_select = '0;
	logic [RATE_W-1:0] display_rate = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SRC_W-1:0] src_x, src_y;
	logic [DIM_W-1:0] src_w, src_h;
	logic signed [16:0] dst_x, dst_y;
	logic [DST_W-1:0] dst_w, dst_h;
	logic [FRAME_W-1:0] shown_frame;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// typed expectation riding along with the input beat
	bit typed_now = 1'b0;
	rect_t typed_want;
	rect_t unused_rect = '{default: '0};

	// predictor copy of the registers and frame state
	logic [DIM_W-1:0] cfg_fw = '0;
	logic [DIM_W-1:0] cfg_fh = '0;
	logic [ZOOM_W-1:0] cfg_zoom = 4'd1;
	logic [FRAME_W-1:0] cfg_fcount = 7'd1;
	logic [FRAME_W-1:0] cfg_trate = 7'd1;
	logic [3:0] cfg_mode = '0;
	logic [FRAME_W-1:0] frame_now = '0;
	bit going_back = 1'b0;
	logic [RATE_W-1:0] skip_left = '0;

	rect_t rects_due[$];
	plan_row_t plan[$];
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit hold_req = 1'b0;

	always #10 clk = ~clk;

	sprite_animation_stepper_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y),
		.row_select(row_select), .display_rate(display_rate),
		.out_valid(out_valid), .out_stall(out_stall),
		.src_x(src_x), .src_y(src_y), .src_w(src_w), .src_h(src_h),
		.dst_x(dst_x), .dst_y(dst_y), .dst_w(dst_w), .dst_h(dst_h),
		.shown_frame(shown_frame),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// rectangles for the frame shown, then step the prescaler and frame counter
	function automatic rect_t next_rects(tick_t t);
		rect_t r;
		int dw, dh, fc, nxt, div;
		dw = int'(cfg_fw) * int'(cfg_zoom);
		dh = int'(cfg_fh) * int'(cfg_zoom);
		r.sw = cfg_fw;
		r.sh = cfg_fh;
		r.dw = DST_W'(dw);
		r.dh = DST_W'(dh);
		r.dx = 17'(int'(t.cx) - dw / 2);
		r.dy = 17'(int'(t.cy) - dh / 2);
		r.sx = '0;
		r.sy = '0;
		r.shown = '0;
		if (cfg_mode[FLAG_ANIM]) begin
			if (cfg_mode[FLAG_MULTI])
				r.sx = SRC_W'(int'(cfg_fw) * int'(t.row));
			r.sy = SRC_W'(int'(cfg_fh) * int'(frame_now));
			r.shown = frame_now;
			if (cfg_mode[FLAG_PLAY]) begin
				if (skip_left != 0) begin
					skip_left = skip_left - RATE_W'(1);
				end else begin
					div = (cfg_trate == 0) ? 1 : int'(cfg_trate);
					fc = (cfg_fcount == 0) ? 1 : int'(cfg_fcount);
					skip_left = RATE_W'(int'(t.rate) / div);
					nxt = going_back ? int'(frame_now) - 1 : int'(frame_now) + 1;
					// end rules: wrap around or turn back
					if (nxt >= fc) begin
						if (cfg_mode[FLAG_PINGPONG]) begin
							going_back = (fc >= 2);
							nxt = (fc >= 2) ? fc - 2 : 0;
						end else begin
							nxt = 0;
						end
					end else if (nxt < 0) begin
						if (cfg_mode[FLAG_PINGPONG]) begin
							going_back = 1'b0;
							nxt = (fc >= 2) ? 1 : 0;
						end else begin
							nxt = fc - 1;
						end
					end
					frame_now = FRAME_W'(nxt);
				end
			end
		end
		return r;
	endfunction

	function automatic rect_t mk_rect(int sx, int sy, int sw, int sh, int dx, int dy,
		int dw, int dh, int shown);
		rect_t r;
		r.sx = SRC_W'(sx);
		r.sy = SRC_W'(sy);
		r.sw = DIM_W'(sw);
		r.sh = DIM_W'(sh);
		r.dx = 17'(dx);
		r.dy = 17'(dy);
		r.dw = DST_W'(dw);
		r.dh = DST_W'(dh);
		r.shown = FRAME_W'(shown);
		return r;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] want,
		logic signed [31:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, seen);
			mismatches++;
		end
	endfunction

	// output beats checked first, then a new input beat is predicted
	always @(posedge clk) begin
		rect_t want, seen, fresh;
		tick_t t;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (rects_due.size() == 0) begin
					$display("%0t: result beat with nothing expected", $time);
					mismatches++;
				end else begin
					want = rects_due.pop_front();
					seen.sx = src_x;
					seen.sy = src_y;
					seen.sw = src_w;
					seen.sh = src_h;
					seen.dx = dst_x;
					seen.dy = dst_y;
					seen.dw = dst_w;
					seen.dh = dst_h;
					seen.shown = shown_frame;
					check_field("src_x", 32'(want.sx), 32'(seen.sx));
					check_field("src_y", 32'(want.sy), 32'(seen.sy));
					check_field("src_w", 32'(want.sw), 32'(seen.sw));
					check_field("src_h", 32'(want.sh), 32'(seen.sh));
					check_field("dst_x", 32'(want.dx), 32'(seen.dx));
					check_field("dst_y", 32'(want.dy), 32'(seen.dy));
					check_field("dst_w", 32'(want.dw), 32'(seen.dw));
					check_field("dst_h", 32'(want.dh), 32'(seen.dh));
					check_field("shown_frame", 32'(want.shown), 32'(seen.shown));
				end
			end
			if (in_valid && !in_stall) begin
				t.cx = pos_x;
				t.cy = pos_y;
				t.row = row_select;
				t.rate = display_rate;
				fresh = next_rects(t);
				rects_due.push_back(typed_now ? typed_want : fresh);
			end
		end
	end

	// receiver stall, with one long hold-off on request
	initial begin
		int hold_cnt;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_cnt == 0 && hold_req) begin
				hold_cnt = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		#4000000;
		$display("tb_top: done, errors");
		$finish;
	end

	task automatic offer_tick(tick_t t, bit typed, rect_t want);
		int gap;
		gap = 0;
		cfg_valid <= 1'b0;
		in_valid <= 1'b1;
		pos_x <= t.cx;
		pos_y <= t.cy;
		row_select <= t.row;
		display_rate <= t.rate;
		typed_now <= typed;
		typed_want <= want;
		do @(posedge clk); while (in_stall);
		while ($urandom_range(99) < idle_pct) gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold the sender until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (rects_due.size() != 0);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FRAME_WIDTH:  cfg_fw = data;
			REG_FRAME_HEIGHT: cfg_fh = data;
			REG_ZOOM:         cfg_zoom = data[ZOOM_W-1:0];
			REG_FRAME_COUNT:  cfg_fcount = data[FRAME_W-1:0];
			REG_TARGET_RATE:  cfg_trate = data[FRAME_W-1:0];
			REG_MODE_FLAGS:   cfg_mode = data[3:0];
			default: ;
		endcase
	endtask

	task automatic plan_cfg(logic [CFG_IDX_W-1:0] idx, int data);
		plan_row_t p;
		p.is_cfg = 1'b1;
		p.idx = idx;
		p.data = CFG_DATA_W'(data);
		p.typed = 1'b0;
		plan.push_back(p);
	endtask

	task automatic plan_tick(int cx, int cy, int row, int rate, bit typed, rect_t want);
		plan_row_t p;
		p.is_cfg = 1'b0;
		p.t.cx = 16'(cx);
		p.t.cy = 16'(cy);
		p.t.row = FRAME_W'(row);
		p.t.rate = RATE_W'(rate);
		p.typed = typed;
		p.want = want;
		plan.push_back(p);
	endtask

	initial begin
		tick_t t;
		bit after_tick;
		logic [CFG_DATA_W-1:0] fw, fh, zm, fc, tr, md;

		// directed rows: reset values, extremes, then every end rule
		plan_tick(32767, -32768, 127, 1023, 1'b1, mk_rect(0, 0, 0, 0, 32767, -32768, 0, 0, 0));
		plan_tick(-32768, 32767, 0, 0, 1'b1, mk_rect(0, 0, 0, 0, -32768, 32767, 0, 0, 0));
		plan_cfg(REG_UNMAPPED, 1023);
		plan_cfg(REG_FRAME_WIDTH, 1023);
		plan_cfg(REG_FRAME_HEIGHT, 1023);
		plan_cfg(REG_ZOOM, 15);
		plan_cfg(REG_FRAME_COUNT, 127);
		plan_cfg(REG_TARGET_RATE, 127);
		// multi-row and play without animated: nothing moves
		plan_cfg(REG_MODE_FLAGS, M_MULTI | M_PLAY | M_PONG);
		plan_tick(0, 0, 127, 1023, 1'b1,
			mk_rect(0, 0, 1023, 1023, -7672, -7672, 15345, 15345, 0));
		plan_cfg(REG_MODE_FLAGS, M_ANIM | M_MULTI | M_PLAY | M_PONG);
		plan_tick(-32768, -32768, 127, 0, 1'b1,
			mk_rect(129921, 0, 1023, 1023, -40440, -40440, 15345, 15345, 0));
		// prescaler reload of one, then it runs down
		plan_tick(32767, 32767, 85, 200, 1'b0, unused_rect);
		plan_tick(1234, -1234, 42, 0, 1'b0, unused_rect);
		plan_tick(-1, 1, 1, 0, 1'b0, unused_rect);
		// frame count lowered to the current frame, ping-pong, zero target rate
		plan_cfg(REG_ZOOM, 0);
		plan_cfg(REG_TARGET_RATE, 0);
		plan_cfg(REG_FRAME_COUNT, 3);
		plan_cfg(REG_MODE_FLAGS, M_ANIM | M_PLAY | M_PONG);
		for (int i = 0; i < 5; i++)
			plan_tick(100 * i, -100 * i, i, 0, 1'b0, unused_rect);
		// wrap-around while counting backward
		plan_cfg(REG_MODE_FLAGS, M_ANIM | M_PLAY);
		for (int i = 0; i < 3; i++)
			plan_tick(-7 * i, 7 * i, 127 - i, 0, 1'b0, unused_rect);
		// zero frame count acts as one
		plan_cfg(REG_FRAME_COUNT, 0);
		plan_tick(5, 5, 3, 0, 1'b0, unused_rect);
		plan_tick(-5, -5, 4, 0, 1'b0, unused_rect);
		// ping-pong with a single frame, reload straight from display rate
		plan_cfg(REG_MODE_FLAGS, M_ANIM | M_PLAY | M_PONG);
		plan_tick(42, -42, 9, 7, 1'b0, unused_rect);
		// animated but paused
		plan_cfg(REG_MODE_FLAGS, M_ANIM | M_MULTI);
		plan_tick(300, 400, 127, 1023, 1'b0, unused_rect);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		after_tick = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (after_tick)
					drain();
				cfg_write(plan[i].idx, plan[i].data);
				after_tick = 1'b0;
			end else begin
				offer_tick(plan[i].t, plan[i].typed, plan[i].want);
				after_tick = 1'b1;
			end
		end

		// random phases, each under its own register setting and one of four idle and stall patterns
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			case (ph)
				0: begin
					fw = 1023; fh = 1023; zm = 15; fc = 127; tr = 127; md = 15;
				end
				1: begin
					fw = 0; fh = 0; zm = 0; fc = 0; tr = 0;
					md = CFG_DATA_W'(M_ANIM | M_PLAY | M_PONG);
				end
				default: begin
					fw = CFG_DATA_W'($urandom_range(1023));
					fh = CFG_DATA_W'($urandom_range(1023));
					zm = CFG_DATA_W'($urandom_range(15));
					case ($urandom_range(9))
						0, 1, 2, 3, 4, 5, 6: fc = CFG_DATA_W'($urandom_range(8, 1));
						7: fc = 0;
						default: fc = CFG_DATA_W'($urandom_range(127, 1));
					endcase
					tr = CFG_DATA_W'(($urandom_range(9) < 6) ? $urandom_range(4)
						: $urandom_range(127));
					if ($urandom_range(3) != 0)
						md = CFG_DATA_W'(M_ANIM | M_PLAY | ($urandom_range(1) ? M_MULTI : 4'd0)
							| ($urandom_range(1) ? M_PONG : 4'd0));
					else
						md = CFG_DATA_W'($urandom_range(15));
				end
			endcase
			cfg_write(REG_FRAME_WIDTH, fw);
			cfg_write(REG_FRAME_HEIGHT, fh);
			cfg_write(REG_ZOOM, zm);
			cfg_write(REG_FRAME_COUNT, fc);
			cfg_write(REG_TARGET_RATE, tr);
			cfg_write(REG_MODE_FLAGS, md);

			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 84; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 84; end
				default: begin idle_pct = 20; stall_pct = 20; end
			endcase
			// long receiver hold-off while the sender keeps offering
			if (ph == 0)
				hold_req = 1'b1;

			for (int i = 0; i < 60; i++) begin
				if (ph == 5 && i == 30)
					drain();
				case ($urandom_range(3))
					0: begin
						t.cx = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
						t.cy = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
					end
					default: begin
						t.cx = 16'($urandom);
						t.cy = 16'($urandom);
					end
				endcase
				t.row = FRAME_W'($urandom_range(127));
				// mostly short reloads so the frame counter hits its ends
				case ($urandom_range(9))
					0, 1, 2, 3, 4, 5: t.rate = RATE_W'($urandom_range(20));
					6, 7: t.rate = RATE_W'($urandom_range(1023));
					8: t.rate = 1023;
					default: t.rate = 0;
				endcase
				offer_tick(t, 1'b0, unused_rect);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
